>>> rtl/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg: shared types, constants and fixed-point helpers
// Payload structs and rounding/saturation for the forward kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none
package sfk_pkg;
  localparam int unsigned JointsDef    = 24;
  localparam int unsigned ValueBitsDef = 16;
  localparam int unsigned FracBits     = 12;
  localparam int unsigned IdxW         = 5;

  typedef struct packed {
    logic [47:0]     location;
    logic [47:0]     rot_row2;
    logic [47:0]     rot_row1;
    logic [47:0]     rot_row0;
    logic [IdxW-1:0] parent_index;
    logic [IdxW-1:0] joint_index;
  } sfk_in_t;

  typedef struct packed {
    logic            parent_error;
    logic [63:0]     rel_row2;
    logic [63:0]     rel_row1;
    logic [63:0]     rel_row0;
    logic [IdxW-1:0] out_joint;
  } sfk_out_t;

  // Read lane k with sign extension from bit vb-1.
  function automatic logic signed [16:0] lane_get(input logic [63:0] w,
                                                  input int unsigned k,
                                                  input int unsigned vb);
    logic [15:0] v;
    logic signed [16:0] s;
    v = w[16*k +: 16];
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s[i] = (i < vb) ? v[i] : v[vb-1];
    end
    s[16] = v[vb-1];
    return s;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [39:0] v,
                                        input int unsigned vb);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = (40'sd1 <<< (vb - 1)) - 40'sd1;
    lo = -hi - 40'sd1;
    if (v > hi) return hi[15:0];
    if (v < lo) return lo[15:0];
    return v[15:0];
  endfunction

  // Round half up from 2^-24 to 2^-12 (arithmetic shift floors), then saturate.
  function automatic logic [15:0] round_sat(input logic signed [39:0] v,
                                            input int unsigned vb);
    logic signed [39:0] x;
    x = (v + 40'sd2048) >>> FracBits;
    return sat16(x, vb);
  endfunction
endpackage
`default_nettype wire

>>> rtl/sfk_ram.sv
// ----------------------------------------------------------------------------
// sfk_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sfk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/sfk_mac.sv
// ----------------------------------------------------------------------------
// sfk_mac: one transform row step
// Three products added to (or, with neg_i, subtracted from) an aligned term,
// rounded and saturated to one lane.
`default_nettype none
module sfk_mac
  import sfk_pkg::*;
#(
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  wire logic signed [16:0] a0_i,
  input  wire logic signed [16:0] a1_i,
  input  wire logic signed [16:0] a2_i,
  input  wire logic signed [16:0] b0_i,
  input  wire logic signed [16:0] b1_i,
  input  wire logic signed [16:0] b2_i,
  input  wire logic signed [16:0] add_i,
  input  wire logic               neg_i,
  output logic             [15:0] res_o
);
  logic signed [39:0] p0, p1, p2, acc;
  always_comb begin
    p0  = 40'(a0_i * b0_i);
    p1  = 40'(a1_i * b1_i);
    p2  = 40'(a2_i * b2_i);
    acc = neg_i ? (40'(add_i) <<< FracBits) - p0 - p1 - p2
                : (40'(add_i) <<< FracBits) + p0 + p1 + p2;
    res_o = round_sat(acc, ValueBits);
  end
endmodule
`default_nettype wire

>>> rtl/skeleton_forward_kinematics.sv
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics: joint-by-joint global transform chain
// Channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_ready_o  | sfk_in_t (joint, parent, rotation, loc)
// out     | out | out_valid_o/out_ready_i| sfk_out_t (joint, relative rows, error)
// A joint is handled in steps: the accept cycle, one parent read, then per row a
// global-row step and a relative translation step through the shared row unit;
// the next joint is accepted only after the last row step. Parent rows and
// location come from RAMs with a registered read. Reset clears control only;
// RAM contents stay undefined until written. A result still held in the output
// register stalls the last row step until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module skeleton_forward_kinematics
  import sfk_pkg::*;
#(
  parameter int unsigned Joints    = JointsDef,
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sfk_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sfk_out_t      out_data_o
);
  localparam int unsigned AW = $clog2(Joints);
  localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StRow0 = 3'd2,
                         StRow1 = 3'd3, StRow2 = 3'd4;

  logic [2:0] state_q, state_d;
  sfk_in_t    item_q;
  logic       root_q, err_q, store_q;
  logic [63:0] g_q [3];
  logic [63:0] rel_q [3];
  logic [1:0]  row;
  logic        phase_q;
  logic        hold, fin;

  logic [63:0] prow [3];
  logic [47:0] ploc;
  logic [AW-1:0] raddr, waddr;

  // Hold the last row step while the previous result waits in the output register
  assign hold = (state_q == StRow2) && phase_q && out_valid_o && !out_ready_i;
  assign fin  = (state_q == StRow2) && phase_q && !hold;

  assign in_ready_o = (state_q == StIdle);
  assign raddr = AW'(in_data_i.parent_index);
  assign waddr = AW'(item_q.joint_index);

  for (genvar r = 0; r < 3; r++) begin : g_rows
    sfk_ram #(.Width(64), .Depth(Joints)) u_grow (
      .clk_i, .we_i(fin && store_q), .waddr_i(waddr),
      .wdata_i(g_q[r]), .raddr_i(raddr), .rdata_o(prow[r]));
  end
  sfk_ram #(.Width(48), .Depth(Joints)) u_loc (
    .clk_i, .we_i(fin && store_q), .waddr_i(waddr),
    .wdata_i(item_q.location), .raddr_i(raddr), .rdata_o(ploc));

  logic [63:0] prow_q [3];
  logic [15:0] t_q [3];
  logic [47:0] rot [3];
  assign rot[0] = item_q.rot_row0;
  assign rot[1] = item_q.rot_row1;
  assign rot[2] = item_q.rot_row2;

  assign row = state_q == StRow0 ? 2'd0 : (state_q == StRow1 ? 2'd1 : 2'd2);

  // Shared unit: phase 0 computes global row lanes, phase 1 relative translation
  logic signed [16:0] ma [3], mb [4][3], madd [4];
  logic [15:0] mres [4];
  logic        mneg;
  always_comb begin
    mneg = phase_q;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 3; k++) begin
        mb[c][k] = '0;
      end
      madd[c] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      ma[k] = lane_get(prow_q[row], k, ValueBits);
    end
    if (!phase_q) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          mb[c][k] = lane_get({16'h0, rot[k]}, c, ValueBits);
        end
      end
      for (int k = 0; k < 3; k++) begin
        mb[3][k] = lane_get({48'h0, t_q[k]}, 0, 16);
      end
      madd[3] = lane_get(prow_q[row], 3, ValueBits);
    end else begin
      for (int k = 0; k < 3; k++) begin
        ma[k] = lane_get(g_q[row], k, ValueBits);
        mb[3][k] = lane_get({16'h0, item_q.location}, k, ValueBits);
      end
      madd[3] = lane_get(g_q[row], 3, ValueBits);
    end
  end
  for (genvar c = 0; c < 4; c++) begin : g_mac
    sfk_mac #(.ValueBits(ValueBits)) u_mac (
      .a0_i(ma[0]), .a1_i(ma[1]), .a2_i(ma[2]),
      .b0_i(mb[c][0]), .b1_i(mb[c][1]), .b2_i(mb[c][2]),
      .add_i(madd[c]), .neg_i(mneg), .res_o(mres[c]));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) state_d = StRead;
      StRead: state_d = StRow0;
      StRow0: if (phase_q) state_d = StRow1;
      StRow1: if (phase_q) state_d = StRow2;
      StRow2: if (fin) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRow0 || state_q == StRow1 || state_q == StRow2) begin
        if (!hold) begin
          phase_q <= !phase_q;
        end
      end else begin
        phase_q <= 1'b0;
      end
      if (fin) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q  <= in_data_i;
      err_q   <= (in_data_i.joint_index != '0) &&
                 (in_data_i.parent_index >= in_data_i.joint_index);
      root_q  <= (in_data_i.joint_index == '0) ||
                 (in_data_i.parent_index >= in_data_i.joint_index);
      store_q <= 32'(in_data_i.joint_index) < Joints;
    end
    if (state_q == StRead) begin
      // Hold parent data; out-of-range or root parents read as zero.
      for (int r = 0; r < 3; r++) begin
        prow_q[r] <= (root_q || 32'(item_q.parent_index) >= Joints) ? '0 : prow[r];
      end
      for (int a = 0; a < 3; a++) begin
        if (root_q) begin
          t_q[a] <= 16'(lane_get({16'h0, item_q.location}, a, ValueBits));
        end else begin
          t_q[a] <= sat16(40'(lane_get({16'h0, item_q.location}, a, ValueBits)) -
                          40'(lane_get({16'h0, (32'(item_q.parent_index) >= Joints)
                                ? 48'h0 : ploc}, a, ValueBits)), ValueBits);
        end
      end
    end
    if (state_q != StIdle && state_q != StRead) begin
      if (!phase_q) begin
        if (root_q) begin
          g_q[row] <= {t_q[row],
                       16'(lane_get({16'h0, rot[row]}, 2, ValueBits)),
                       16'(lane_get({16'h0, rot[row]}, 1, ValueBits)),
                       16'(lane_get({16'h0, rot[row]}, 0, ValueBits))};
        end else begin
          g_q[row] <= {mres[3], mres[2], mres[1], mres[0]};
        end
      end else begin
        rel_q[row] <= {mres[3], g_q[row][47:0]};
      end
    end
    if (fin) begin
      out_data_o.out_joint    <= item_q.joint_index;
      out_data_o.rel_row0     <= rel_q[0];
      out_data_o.rel_row1     <= rel_q[1];
      out_data_o.rel_row2     <= {mres[3], g_q[2][47:0]};
      out_data_o.parent_error <= err_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle))
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (state_q == StRow0 || state_q == StRow1 || state_q == StRow2))
    else $error("phase set outside row steps");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_o)
    else $error("result not presented");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: forward kinematics chain check
// Feeds joints in tree order, predicts global and relative transforms and
// compares each result against the prediction with random idles on both ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sfk_pkg::*;

  localparam int NJ = 24;
  localparam int WDOG = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sfk_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sfk_out_t out_data;

  skeleton_forward_kinematics u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the pose chain
  logic [63:0] glob_q [NJ][3];
  logic [47:0] loc_q [NJ];
  bit          written_q [NJ];
  sfk_out_t    pose_exp_q[$];
  int          mism_cnt = 0;
  int          idle_cnt = 0;
  bit          no_idle = 1'b0;
  bit          hold_out = 1'b0;

  function automatic longint lane(input logic [63:0] w, input int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  function automatic longint clamp(input longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint rnd(input longint v);
    return clamp((v + 2048) >>> 12);
  endfunction

  function automatic sfk_out_t pose_predict(input sfk_in_t it);
    sfk_out_t o;
    longint r[3][3], jl[3], t[3], pr[3][4], g[3][4], acc;
    logic [63:0] pw[3], gw, rw;
    logic [47:0] pl;
    bit err, root;
    int ji, pi;
    ji = int'(it.joint_index);
    pi = int'(it.parent_index);
    err = (ji != 0) && (pi >= ji);
    root = (ji == 0) || err;
    pw = '{default: '0};
    pl = '0;
    if (!root && pi < NJ) begin
      pw = glob_q[pi];
      pl = loc_q[pi];
    end
    for (int a = 0; a < 3; a++) begin
      r[0][a] = lane(it.rot_row0, a);
      r[1][a] = lane(it.rot_row1, a);
      r[2][a] = lane(it.rot_row2, a);
      jl[a] = lane(it.location, a);
      t[a] = root ? jl[a] : clamp(jl[a] - lane(pl, a));
      for (int b = 0; b < 4; b++) pr[a][b] = lane(pw[a], b);
    end
    for (int a = 0; a < 3; a++) begin
      if (root) begin
        for (int b = 0; b < 3; b++) g[a][b] = r[a][b];
        g[a][3] = t[a];
      end else begin
        for (int b = 0; b < 3; b++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += pr[a][k] * r[k][b];
          g[a][b] = rnd(acc);
        end
        acc = pr[a][3] * 4096;
        for (int k = 0; k < 3; k++) acc += pr[a][k] * t[k];
        g[a][3] = rnd(acc);
      end
    end
    for (int a = 0; a < 3; a++) begin
      acc = g[a][3] * 4096;
      gw = '0;
      for (int k = 0; k < 3; k++) begin
        acc -= g[a][k] * jl[k];
        gw[16*k +: 16] = g[a][k][15:0];
      end
      rw = gw;
      rw[63:48] = 16'(rnd(acc));
      gw[63:48] = g[a][3][15:0];
      pw[a] = rw;
      if (ji < NJ) glob_q[ji][a] = gw;
    end
    if (ji < NJ) begin
      loc_q[ji] = it.location;
      written_q[ji] = 1'b1;
    end
    o.out_joint = it.joint_index;
    o.rel_row0 = pw[0];
    o.rel_row1 = pw[1];
    o.rel_row2 = pw[2];
    o.parent_error = err;
    return o;
  endfunction

  function automatic logic [47:0] rand_word();
    return {$urandom(), 16'($urandom())};
  endfunction

  // mostly rotation-like values, with some full-range noise
  function automatic logic [47:0] rand_lanes();
    logic [47:0] w;
    if ($urandom_range(0, 3) == 0) return rand_word();
    for (int k = 0; k < 3; k++) w[16*k +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
    return w;
  endfunction

  // joint with a written, smaller parent index; joint 0 gets parent 0
  function automatic sfk_in_t rand_joint(input int ji);
    sfk_in_t it;
    int pi;
    it.joint_index = 5'(ji);
    pi = 0;
    if (ji > 0) begin
      pi = $urandom_range(0, ji - 1);
      while (!written_q[pi]) pi = $urandom_range(0, ji - 1);
    end
    it.parent_index = 5'(pi);
    it.rot_row0 = rand_lanes();
    it.rot_row1 = rand_lanes();
    it.rot_row2 = rand_lanes();
    it.location = rand_lanes();
    return it;
  endfunction

  // drop valid only while idling; keep it high across back-to-back transactions
  task automatic send_pose(input sfk_in_t it);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pose_exp_q = {pose_exp_q, pose_predict(it)};
    @(negedge clk_i);
  endtask

  // receiver: random ready, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_out) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk_i) begin
    sfk_out_t exp_o;
    if (rst_ni && out_valid && out_ready) begin
      if (pose_exp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected transaction %p", out_data);
      end else begin
        exp_o = pose_exp_q.pop_front();
        if (out_data !== exp_o) begin
          mism_cnt++;
          if (mism_cnt <= 10) $display("mismatch joint %0d: exp %p got %p",
                                       exp_o.out_joint, exp_o, out_data);
        end
      end
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // directed table: expected result typed in where it is obvious
  typedef struct {
    sfk_in_t  stim;
    bit       typed;
    sfk_out_t res;
  } pose_row_t;

  pose_row_t dir_tbl[$];

  task automatic add_row(input int ji, input int pi, input logic [47:0] r0,
                         input logic [47:0] r1, input logic [47:0] r2,
                         input logic [47:0] lc);
    pose_row_t row;
    row.stim = '{location: lc, rot_row2: r2, rot_row1: r1, rot_row0: r0,
                 parent_index: 5'(pi), joint_index: 5'(ji)};
    row.typed = 1'b0;
    row.res = '0;
    dir_tbl = {dir_tbl, row};
  endtask

  initial begin
    sfk_out_t got;
    int depth;
    // root with zero pose: all-zero result
    add_row(0, 0, '0, '0, '0, '0);
    dir_tbl[0].typed = 1'b1;
    add_row(0, 31, 48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
            48'h0100_0200_0300);
    add_row(1, 0, 48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
            48'h0400_0500_0600);
    // bad parent: handled as a root, flag raised, zero pose gives zero rows
    add_row(2, 2, '0, '0, '0, '0);
    dir_tbl[3].typed = 1'b1;
    dir_tbl[3].res = '{parent_error: 1'b1, rel_row2: '0, rel_row1: '0, rel_row0: '0,
                       out_joint: 5'd2};
    add_row(3, 31, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
    add_row(4, 1, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}});
    add_row(5, 4, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}});
    add_row(6, 5, {3{16'hffff}}, {3{16'h0001}}, {3{16'hffff}}, {3{16'hffff}});
    add_row(23, 6, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}});
    add_row(23, 23, {3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}});
    // joint beyond the store: emitted, not stored
    add_row(31, 23, {3{16'h1000}}, '0, {3{16'h1000}}, 48'h0800_0800_0800);
    add_row(24, 3, 48'haaaa_5555_aaaa, 48'h5555_aaaa_5555, 48'h1234_5678_9abc,
            48'hfedc_ba98_7654);
    add_row(7, 3, 48'h5555_aaaa_5555, 48'haaaa_5555_aaaa, 48'h0fed_cba9_8765,
            48'h0123_4567_89ab);

    rst_ni = 1'b0;
    written_q = '{default: 1'b0};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      send_pose(dir_tbl[i].stim);
      if (dir_tbl[i].typed) begin
        got = pose_exp_q[$];
        if (got !== dir_tbl[i].res) begin
          mism_cnt++;
          if (mism_cnt <= 10) $display("row %0d: exp %p pred %p", i, dir_tbl[i].res, got);
        end
      end
    end

    // random skeletons in tree order, with some noise items
    for (int n = 0; n < 1450; ) begin
      if (n >= 500 && n < 600) no_idle = 1'b1;
      else no_idle = 1'b0;
      if (n >= 800 && n < 830) begin
        // hold the receiver so the block fills and stalls its input
        fork
          begin
            hold_out = 1'b1;
            for (int c = 0; c < 300; c++) @(posedge clk_i);
            hold_out = 1'b0;
          end
          for (int k = 0; k < 30; k++) send_pose(rand_joint(k % 20));
        join
        n += 30;
      end else if ($urandom_range(0, 9) == 0) begin
        sfk_in_t it;
        it = rand_joint($urandom_range(0, 31));
        it.parent_index = 5'($urandom_range(0, 31));
        if (it.joint_index != 0 && it.parent_index < it.joint_index &&
            (it.parent_index >= NJ || !written_q[it.parent_index]))
          it.parent_index = it.joint_index;
        send_pose(it);
        n++;
      end else begin
        depth = $urandom_range(2, NJ);
        for (int k = 0; k < depth; k++) send_pose(rand_joint(k));
        n += depth;
      end
    end
    in_valid <= 1'b0;

    while (pose_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
